// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared widths, command codes and the cell control bundle of the queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Payload widths fixed by the channel format.
  localparam int KEY_W   = 32;
  localparam int CMD_W   = 2;
  localparam int ENTRY_W = 5;

  // Command codes; the unused code behaves as a peek.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  // Broadcast from the top level to every cell in a cycle.
  typedef struct packed {
    logic                    ins_en;
    logic                    pop_en;
    logic signed [KEY_W-1:0] new_key;
  } cell_ctl_t;

endpackage

// ===== src/smpq_if.sv =====
// ----------------------------------------------------------------------------
// smpq_in_if / smpq_out_if
// Valid/ready channels for commands into the queue and results out of it.
// ----------------------------------------------------------------------------
interface smpq_in_if;
  logic                             valid;
  logic                             ready;
  logic [smpq_pkg::CMD_W-1:0]       command;
  logic signed [smpq_pkg::KEY_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface smpq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [smpq_pkg::KEY_W-1:0] head_value;
  logic                              queue_empty;
  logic [smpq_pkg::ENTRY_W-1:0]      entry_count;
  logic                              overflow;
  logic                              underflow;

  modport source (output valid, output head_value, output queue_empty,
                  output entry_count, output overflow, output underflow,
                  input ready);
  modport sink   (input valid, input head_value, input queue_empty,
                  input entry_count, input overflow, input underflow,
                  output ready);
endinterface

// ===== src/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell
// One storage cell of the sorted chain: holds a key, tells its right
// neighbor whether the new key lands at or before it, and shifts.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                              clk,
  input  smpq_pkg::cell_ctl_t               ctl,
  input  logic                              occupied,
  input  logic                              left_goes,
  input  logic signed [smpq_pkg::KEY_W-1:0] left_key,
  input  logic signed [smpq_pkg::KEY_W-1:0] right_key,
  output logic                              goes,
  output logic signed [smpq_pkg::KEY_W-1:0] key_out,
  output logic signed [smpq_pkg::KEY_W-1:0] key_nxt
);
  import smpq_pkg::*;

  logic signed [KEY_W-1:0] key_r;

  // The new key belongs at or before this cell when the cell is free or
  // holds a key that is not smaller than the new one.
  assign goes = !occupied || (key_r >= ctl.new_key);

  // Insert shifts toward higher cells, pop shifts toward cell zero.
  always_comb begin
    priority if (ctl.ins_en) begin
      if (goes) begin
        key_nxt = left_goes ? left_key : ctl.new_key;
      end else begin
        key_nxt = key_r;
      end
    end else if (ctl.pop_en) begin
      key_nxt = right_key;
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_out = key_r;

endmodule

// ===== src/sorted_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Minimum priority queue of signed keys kept in ascending order in a chain
// of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one command per beat: insert value, pop the smallest key
//   or peek. out_chan returns one result beat per command: the smallest key
//   after the command (zero when empty), the empty flag, the entry count and
//   the overflow and underflow flags.
//   Every cell compares its key against the new key in the same cycle and
//   shifts one place left or right; a command is accepted at a clock edge
//   and its result is valid right after that edge.
//   One command per cycle is sustained while out_chan.ready stays high; the
//   cycle time is set by the new key fanned out to all CAPACITY cells and the compare in each cell.
//   A single output register sits between the channels; while it holds an
//   unaccepted result, in_chan.ready is low until out_chan.ready is high.
//   An insert into a full queue leaves it unchanged and sets overflow; a pop
//   on an empty queue leaves it unchanged and sets underflow.
//   Reset empties the queue and drops any pending result; the cell keys are
//   not cleared, only the entry count decides which cells hold data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_min_priority_queue #(
  parameter int CAPACITY = 16
) (
  input logic         clk,
  input logic         rst_n,
  smpq_in_if.sink     in_chan,
  smpq_out_if.source  out_chan
);
  import smpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > ENTRY_W) ? CW : ENTRY_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] head_r;
  logic                    empty_r, ovf_r, unf_r;
  logic [ENTRY_W-1:0]      entry_r;

  logic                    accept, is_ins, is_pop, full, empty;
  cell_ctl_t               ctl;
  logic [EW-1:0]           count_ext;

  logic                    occupied [CAPACITY];
  logic                    goes_w   [CAPACITY];
  logic signed [KEY_W-1:0] key_q    [CAPACITY];
  logic signed [KEY_W-1:0] key_n    [CAPACITY];

  // Command decode and handshake.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_ins        = (in_chan.command == CMD_INSERT);
  assign is_pop        = (in_chan.command == CMD_POP);
  assign full          = (count_r == CAP_CNT);
  assign empty         = (count_r == '0);

  assign ctl.ins_en  = accept && is_ins && !full;
  assign ctl.pop_en  = accept && is_pop && !empty;
  assign ctl.new_key = in_chan.value;

  // The chain of cells, cell zero holds the smallest key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      smpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (occupied[i]),
        .left_goes (1'b0),
        .left_key  (ctl.new_key),
        .right_key (key_q[i+1]),
        .goes      (goes_w[i]),
        .key_out   (key_q[i]),
        .key_nxt   (key_n[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      smpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (occupied[i]),
        .left_goes (goes_w[i-1]),
        .left_key  (key_q[i-1]),
        .right_key (key_q[i]),
        .goes      (goes_w[i]),
        .key_out   (key_q[i]),
        .key_nxt   (key_n[i])
      );
    end else begin : g_mid
      smpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (occupied[i]),
        .left_goes (goes_w[i-1]),
        .left_key  (key_q[i-1]),
        .right_key (key_q[i+1]),
        .goes      (goes_w[i]),
        .key_out   (key_q[i]),
        .key_nxt   (key_n[i])
      );
    end
  end

  // Entry count follows the insert and pop enables.
  always_comb begin
    priority if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop_en) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign count_ext = EW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register: loaded with the state after the accepted command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r  <= (count_nxt == '0) ? '0 : key_n[0];
      empty_r <= (count_nxt == '0);
      entry_r <= count_ext[ENTRY_W-1:0];
      ovf_r   <= accept && is_ins && full;
      unf_r   <= accept && is_pop && empty;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.head_value  = head_r;
  assign out_chan.queue_empty = empty_r;
  assign out_chan.entry_count = entry_r;
  assign out_chan.overflow    = ovf_r;
  assign out_chan.underflow   = unf_r;

  // Checks on the queue control.
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_CNT, "entry count above capacity")
  `ASSERT_NEXT(a_full_insert, clk, rst_n, accept && is_ins && full, out_chan.valid && out_chan.overflow && (count_r == CAP_CNT), "insert into full queue not flagged")
  `ASSERT_NEXT(a_pop_count, clk, rst_n, accept && is_pop && !empty, count_r == $past(count_r) - CW'(1), "pop did not remove one entry")
  `ASSERT_IMPL(a_no_both, clk, rst_n, 1'b1, !(ctl.ins_en && ctl.pop_en), "insert and pop enabled together")

endmodule
